/* hdl/ssmd_pkg.sv */
// Shared constants, types and font lookup for the seven-segment display controller.
// Depends on nothing; used by seven_segment_mux_display and by its checker and test.
package ssmd_pkg;

    localparam int DIGITS    = 4;
    localparam int ROW_COUNT = 2;

    localparam int STORE_DEPTH = 8;
    localparam int SEG_W       = 8;
    localparam int TIMER_W     = 12;
    localparam int LED_W       = 4;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 12;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 24;

    localparam logic [TIMER_W-1:0] HALF_PERIOD_RESET = 12'd200;
    localparam logic [TIMER_W-1:0] HOLD_TIME_RESET   = 12'd800;

    localparam logic [2:0] DIGITS_C    = 3'(DIGITS);
    localparam logic [1:0] ROW_COUNT_C = 2'(ROW_COUNT);

    typedef enum logic [2:0] {
        K_TICK       = 3'd0,
        K_PUT_CHAR   = 3'd1,
        K_SET_CURSOR = 3'd2,
        K_SET_BLINK  = 3'd3,
        K_CLEAR      = 3'd4
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DISPLAY_ON  = 8'd0,
        REG_LED_STATE   = 8'd1,
        REG_HALF_PERIOD = 8'd2,
        REG_HOLD_TIME   = 8'd3
    } t_reg_index;

    localparam logic [6:0] DIGIT_ZERO  = 7'h30;
    localparam logic [6:0] DIGIT_NINE  = 7'h39;
    localparam logic [6:0] DIRECT_LAST = 7'h0F;
    localparam logic [4:0] SYM_DASH    = 5'h1D;
    localparam logic [4:0] SYM_BLANK   = 5'h1E;
    localparam logic [SEG_W-1:0] SEG_POINT = 8'h20;

    typedef logic [SEG_W-1:0] t_font [0:30];

    localparam t_font FONT_ROM = '{
        8'hD7, 8'h14, 8'hCE, 8'h9E, 8'h1D, 8'h9B, 8'hDB, 8'h16,
        8'hDF, 8'h9F, 8'h5F, 8'hD9, 8'hC8, 8'hDC, 8'hCB, 8'h4B,
        8'hD3, 8'h5D, 8'hC1, 8'h58, 8'hD8, 8'h4F, 8'h48, 8'hC9,
        8'hD0, 8'hD5, 8'h9D, 8'hC3, 8'h0F, 8'h08, 8'h00
    };

    // Map a 7-bit character symbol to its font entry.
    function automatic logic [4:0] symbol_index(input logic [6:0] c);
        logic [4:0] idx;
        if (c inside {[DIGIT_ZERO:DIGIT_NINE]}) begin
            idx = 5'(c - DIGIT_ZERO);
        end else if (c <= DIRECT_LAST) begin
            idx = c[4:0];
        end else begin
            case (c)
                7'h41:   idx = 5'h0A;  // A
                7'h62:   idx = 5'h0B;  // b
                7'h63:   idx = 5'h0C;  // c
                7'h43:   idx = 5'h1B;  // C
                7'h64:   idx = 5'h0D;  // d
                7'h45:   idx = 5'h0E;  // E
                7'h46:   idx = 5'h0F;  // F
                7'h47:   idx = 5'h10;  // G
                7'h48:   idx = 5'h11;  // H
                7'h49:   idx = 5'h01;  // I
                7'h4C:   idx = 5'h12;  // L
                7'h6E:   idx = 5'h13;  // n
                7'h6F:   idx = 5'h14;  // o
                7'h4F:   idx = 5'h00;  // O
                7'h50:   idx = 5'h15;  // P
                7'h72:   idx = 5'h16;  // r
                7'h53:   idx = 5'h05;  // S
                7'h74:   idx = 5'h17;  // t
                7'h75:   idx = 5'h18;  // u
                7'h55:   idx = 5'h19;  // U
                7'h59:   idx = 5'h1A;  // Y
                7'h2A:   idx = 5'h1C;  // star
                7'h20:   idx = SYM_BLANK;
                default: idx = SYM_DASH;
            endcase
        end
        return idx;
    endfunction

    function automatic logic [SEG_W-1:0] font_lookup(input logic [4:0] idx);
        logic [SEG_W-1:0] seg;
        seg = (idx <= 5'd30) ? FONT_ROM[idx] : '0;
        return seg;
    endfunction

endpackage

/* hdl/seven_segment_mux_display.sv */
// Top level of the multiplexed seven-segment display controller.
// Depends on ssmd_pkg for the font table, codes and sizes.
//
// Usage:
//   Slave stream (i_s_*): one word per request. tuser carries the kind
//   (tick, put character, set cursor, set blink, clear). Only a tick gives
//   a result: one 24-bit shift-register word on the master stream (o_m_*).
//   Configuration channel (i_cfg_*): register index and data, always ready;
//   write it only while no request is outstanding.
// Timing:
//   Each word is handled in the cycle it is accepted: the display state
//   updates at that edge and a tick's result sits in the output register
//   from the next cycle on. One word per cycle is taken, set by the
//   single output register: while it holds an untaken result and the
//   receiver keeps tready low, o_s_tready drops until the result leaves.
// Reset:
//   Synchronous, active low. Clears the segment store, cursor, scan phase,
//   blink mask and timer, marks the blink visible, drops the output valid
//   and loads the register reset values (display on, LEDs off, half period
//   200, hold time 800).
module seven_segment_mux_display (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // tdata: [7:0] char_code, [9:8] cursor_row, [12:10] cursor_digit,
    //        [20:13] blink_select, [21] keep_blink_select, [23:22] zero
    input  logic [ssmd_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // tuser: [2:0] kind
    input  logic [2:0]                          i_s_tuser,
    // master stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // tdata: [23:0] shift_word
    output logic [ssmd_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ssmd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ssmd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int SW = ssmd_pkg::SEG_W;
    localparam int TW = ssmd_pkg::TIMER_W;

    // configuration registers
    logic                         r_display_on;
    logic [ssmd_pkg::LED_W-1:0]   r_led_state;
    logic [TW-1:0]                r_half_period;
    logic [TW-1:0]                r_hold_time;

    // display state
    logic [SW-1:0] r_store [ssmd_pkg::STORE_DEPTH];
    logic [SW-1:0] n_store [ssmd_pkg::STORE_DEPTH];
    logic [1:0]    r_scan_phase, n_scan_phase;
    logic          r_write_row,  n_write_row;
    logic [1:0]    r_write_digit, n_write_digit;
    logic [7:0]    r_blink_mask, n_blink_mask;
    logic          r_blink_visible, n_blink_visible;
    logic [TW-1:0] r_countdown, n_countdown;

    // output register
    logic                              r_m_valid;
    logic [ssmd_pkg::OUT_DATA_W-1:0]   r_m_data;
    logic [ssmd_pkg::OUT_DATA_W-1:0]   n_m_data;

    // unpacked request
    ssmd_pkg::t_kind in_kind;
    logic [7:0]      in_char;
    logic [1:0]      in_row;
    logic [2:0]      in_digit;
    logic [7:0]      in_blink_sel;
    logic            in_keep;

    logic s_accept, m_accept, tick_accept;

    assign in_kind      = ssmd_pkg::t_kind'(i_s_tuser);
    assign in_char      = i_s_tdata[7:0];
    assign in_row       = i_s_tdata[9:8];
    assign in_digit     = i_s_tdata[12:10];
    assign in_blink_sel = i_s_tdata[20:13];
    assign in_keep      = i_s_tdata[21];

    // Take a new word whenever the output register is free or being drained.
    assign o_s_tready  = !r_m_valid || i_m_tready;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign m_accept    = r_m_valid && i_m_tready;
    assign tick_accept = s_accept && (in_kind == ssmd_pkg::K_TICK);
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_data;
    assign o_cfg_ready = 1'b1;

    // Next-state logic for one request.
    always_comb begin
        logic [TW-1:0] cd_dec;
        logic [SW-1:0] top, bot, seg;
        logic [7:0]    scans;
        logic [7:0]    row_bits;
        logic [2:0]    digit_inc, phase_inc;
        logic [2:0]    store_addr;

        for (int i = 0; i < ssmd_pkg::STORE_DEPTH; i++) begin
            n_store[i] = r_store[i];
        end
        n_scan_phase    = r_scan_phase;
        n_write_row     = r_write_row;
        n_write_digit   = r_write_digit;
        n_blink_mask    = r_blink_mask;
        n_blink_visible = r_blink_visible;
        n_countdown     = r_countdown;

        cd_dec     = (r_countdown != '0) ? r_countdown - 1'b1 : '0;
        top        = r_store[{1'b0, r_scan_phase}];
        bot        = r_store[{1'b1, r_scan_phase}];
        scans      = '0;
        row_bits   = r_write_row ? 8'hF0 : 8'h0F;
        digit_inc  = {1'b0, r_write_digit} + 3'd1;
        phase_inc  = {1'b0, r_scan_phase} + 3'd1;
        store_addr = {r_write_row, r_write_digit};
        seg        = ssmd_pkg::font_lookup(ssmd_pkg::symbol_index(in_char[6:0]));
        if (in_char[7]) begin
            seg = seg | ssmd_pkg::SEG_POINT;
        end

        case (in_kind)
            ssmd_pkg::K_TICK: begin
                n_countdown = cd_dec;
                if (r_blink_mask != '0 && cd_dec == '0) begin
                    n_countdown     = r_half_period;
                    n_blink_visible = !r_blink_visible;
                end
                // Blank masked digits while the blink phase is dark.
                if (!n_blink_visible) begin
                    if (r_blink_mask[{1'b0, r_scan_phase}]) top = '0;
                    if (r_blink_mask[{1'b1, r_scan_phase}]) bot = '0;
                end
                if (r_display_on) begin
                    scans[3'(r_scan_phase) + 3'd1] = 1'b1;
                end
                scans[0] = r_led_state[0];
                scans[5] = r_led_state[1];
                scans[6] = r_led_state[2];
                scans[7] = r_led_state[3];
                n_scan_phase = (phase_inc >= ssmd_pkg::DIGITS_C) ? 2'd0 : phase_inc[1:0];
            end
            ssmd_pkg::K_PUT_CHAR: begin
                // Hold the blink on while its row is being written.
                if ((r_blink_mask & row_bits) != '0) begin
                    n_blink_visible = 1'b1;
                    n_countdown     = r_hold_time;
                end
                n_store[store_addr] = seg;
                if (digit_inc >= ssmd_pkg::DIGITS_C) begin
                    n_write_digit = 2'd0;
                    if (2'({1'b0, r_write_row} + 2'd1) >= ssmd_pkg::ROW_COUNT_C) begin
                        n_write_row = 1'b0;
                    end else begin
                        n_write_row = 1'b1;
                    end
                end else begin
                    n_write_digit = digit_inc[1:0];
                end
            end
            ssmd_pkg::K_SET_CURSOR: begin
                if ({1'b0, in_row} < {1'b0, ssmd_pkg::ROW_COUNT_C}
                        && in_digit < ssmd_pkg::DIGITS_C) begin
                    n_write_row   = in_row[0];
                    n_write_digit = in_digit[1:0];
                end
            end
            ssmd_pkg::K_SET_BLINK: begin
                if (!in_keep) begin
                    n_blink_mask = in_blink_sel;
                end
                n_countdown     = r_half_period;
                n_blink_visible = 1'b0;
            end
            ssmd_pkg::K_CLEAR: begin
                for (int i = 0; i < ssmd_pkg::STORE_DEPTH; i++) begin
                    n_store[i] = '0;
                end
                n_write_row   = 1'b0;
                n_write_digit = 2'd0;
            end
            default: begin
                // unused kinds: drop without effect
            end
        endcase

        n_m_data = {scans, top, bot};
    end

    // Display state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ssmd_pkg::STORE_DEPTH; i++) begin
                r_store[i] <= '0;
            end
            r_scan_phase    <= '0;
            r_write_row     <= 1'b0;
            r_write_digit   <= '0;
            r_blink_mask    <= '0;
            r_blink_visible <= 1'b1;
            r_countdown     <= '0;
            r_m_valid       <= 1'b0;
        end else begin
            if (s_accept) begin
                for (int i = 0; i < ssmd_pkg::STORE_DEPTH; i++) begin
                    r_store[i] <= n_store[i];
                end
                r_scan_phase    <= n_scan_phase;
                r_write_row     <= n_write_row;
                r_write_digit   <= n_write_digit;
                r_blink_mask    <= n_blink_mask;
                r_blink_visible <= n_blink_visible;
                r_countdown     <= n_countdown;
            end
            if (tick_accept) begin
                r_m_valid <= 1'b1;
            end else if (m_accept) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_accept) begin
            r_m_data <= n_m_data;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_on  <= 1'b1;
            r_led_state   <= '0;
            r_half_period <= ssmd_pkg::HALF_PERIOD_RESET;
            r_hold_time   <= ssmd_pkg::HOLD_TIME_RESET;
        end else if (i_cfg_valid) begin
            case (ssmd_pkg::t_reg_index'(i_cfg_index))
                ssmd_pkg::REG_DISPLAY_ON:  r_display_on  <= i_cfg_data[0];
                ssmd_pkg::REG_LED_STATE:   r_led_state   <= i_cfg_data[ssmd_pkg::LED_W-1:0];
                ssmd_pkg::REG_HALF_PERIOD: r_half_period <= i_cfg_data[TW-1:0];
                ssmd_pkg::REG_HOLD_TIME:   r_hold_time   <= i_cfg_data[TW-1:0];
                default: begin
                    // index beyond the register list: ignore
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_scan_phase} < ssmd_pkg::DIGITS_C)
        else $error("scan phase beyond digit count");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_write_digit} < ssmd_pkg::DIGITS_C)
        else $error("write cursor beyond digit count");

    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_accept |=> o_m_tvalid)
        else $error("accepted tick gave no result");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid && !tick_accept) |=> !o_m_tvalid)
        else $error("result appeared without a tick");

    a_one_scan_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> $onehot0(o_m_tdata[20:17]))
        else $error("more than one scan line driven");
`endif

endmodule

/* bench/seven_segment_mux_display_checker.sv */
// Scoreboard for the seven-segment display controller: watches the request, result and
// register channels, predicts each shift word and compares it. Depends on ssmd_pkg.
module seven_segment_mux_display_checker
    import ssmd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic [2:0]            i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_MAX = 10;

    localparam logic [6:0] CODE_ZERO       = 7'h30;
    localparam logic [6:0] CODE_NINE       = 7'h39;
    localparam logic [6:0] CODE_DIRECT_MAX = 7'h0F;
    localparam logic [4:0] GLYPH_DASH      = 5'h1D;
    localparam logic [4:0] GLYPH_BLANK     = 5'h1E;
    localparam logic [7:0] POINT_SEG       = 8'h20;

    // Segment patterns, bit order F A B G C point E D from bit 0 up.
    localparam logic [7:0] GLYPH [0:30] = '{
        8'hD7, 8'h14, 8'hCE, 8'h9E, 8'h1D, 8'h9B, 8'hDB, 8'h16,
        8'hDF, 8'h9F, 8'h5F, 8'hD9, 8'hC8, 8'hDC, 8'hCB, 8'h4B,
        8'hD3, 8'h5D, 8'hC1, 8'h58, 8'hD8, 8'h4F, 8'h48, 8'hC9,
        8'hD0, 8'hD5, 8'h9D, 8'hC3, 8'h0F, 8'h08, 8'h00
    };

    logic [7:0]  seg_store [0:7];
    logic [1:0]  scan_pos;
    logic        cur_row;
    logic [1:0]  cur_digit;
    logic [7:0]  blink_sel;
    logic        blink_lit;
    logic [11:0] blink_timer;
    logic        shown;
    logic [3:0]  leds;
    logic [11:0] half_period;
    logic [11:0] hold_ticks;

    logic [OUT_DATA_W-1:0] scan_words_due [$];
    int                    mismatches = 0;

    function automatic logic [7:0] segments_for(input logic [7:0] code);
        logic [6:0] sym;
        logic [4:0] idx;
        sym = code[6:0];
        if (sym >= CODE_ZERO && sym <= CODE_NINE) begin
            idx = 5'(sym - CODE_ZERO);
        end else if (sym <= CODE_DIRECT_MAX) begin
            idx = sym[4:0];
        end else begin
            case ({1'b0, sym})
                "A":     idx = 5'h0A;
                "b":     idx = 5'h0B;
                "c":     idx = 5'h0C;
                "C":     idx = 5'h1B;
                "d":     idx = 5'h0D;
                "E":     idx = 5'h0E;
                "F":     idx = 5'h0F;
                "G":     idx = 5'h10;
                "H":     idx = 5'h11;
                "I":     idx = 5'h01;
                "L":     idx = 5'h12;
                "n":     idx = 5'h13;
                "o":     idx = 5'h14;
                "O":     idx = 5'h00;
                "P":     idx = 5'h15;
                "r":     idx = 5'h16;
                "S":     idx = 5'h05;
                "t":     idx = 5'h17;
                "u":     idx = 5'h18;
                "U":     idx = 5'h19;
                "Y":     idx = 5'h1A;
                "*":     idx = 5'h1C;
                " ":     idx = GLYPH_BLANK;
                default: idx = GLYPH_DASH;
            endcase
        end
        return GLYPH[idx] | (code[7] ? POINT_SEG : 8'h00);
    endfunction

    // Form the word for the current phase, run the blink timer, advance the phase.
    function automatic logic [OUT_DATA_W-1:0] next_scan_word();
        logic [1:0] ph;
        logic [7:0] top_seg;
        logic [7:0] bot_seg;
        logic [7:0] scans;
        ph      = scan_pos;
        top_seg = seg_store[{1'b0, ph}];
        bot_seg = seg_store[{1'b1, ph}];
        if (blink_timer != 0) begin
            blink_timer = blink_timer - 1'b1;
        end
        if (blink_sel != 0) begin
            if (blink_timer == 0) begin
                blink_timer = half_period;
                blink_lit   = ~blink_lit;
            end
            if (!blink_lit) begin
                if (blink_sel[{1'b0, ph}]) top_seg = 8'h00;
                if (blink_sel[{1'b1, ph}]) bot_seg = 8'h00;
            end
        end
        scans = {leds[3], leds[2], leds[1], 4'b0000, leds[0]};
        if (shown) begin
            scans[ph + 3'd1] = 1'b1;
        end
        scan_pos = ph + 2'd1;
        return {scans, top_seg, bot_seg};
    endfunction

    task automatic clear_store();
        for (int i = 0; i < 8; i++) seg_store[i] = 8'h00;
        cur_row   = 1'b0;
        cur_digit = 2'd0;
    endtask

    // tdata: [7:0] char, [9:8] row, [12:10] digit, [20:13] blink select, [21] keep
    task automatic apply_request(input logic [2:0] kind, input logic [IN_DATA_W-1:0] data);
        case (kind)
            K_TICK: begin
                scan_words_due.push_back(next_scan_word());
            end
            K_PUT_CHAR: begin
                if ((blink_sel & (cur_row ? 8'hF0 : 8'h0F)) != 0) begin
                    blink_lit   = 1'b1;
                    blink_timer = hold_ticks;
                end
                seg_store[{cur_row, cur_digit}] = segments_for(data[7:0]);
                if (cur_digit == 2'(DIGITS - 1)) begin
                    cur_digit = 2'd0;
                    cur_row   = ~cur_row;
                end else begin
                    cur_digit = cur_digit + 2'd1;
                end
            end
            K_SET_CURSOR: begin
                if (data[9:8] < ROW_COUNT && data[12:10] < DIGITS) begin
                    cur_row   = data[8];
                    cur_digit = data[11:10];
                end
            end
            K_SET_BLINK: begin
                if (!data[21]) blink_sel = data[20:13];
                blink_timer = half_period;
                blink_lit   = 1'b0;
            end
            K_CLEAR: begin
                clear_store();
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        logic [OUT_DATA_W-1:0] want;
        if (!i_rst_n) begin
            clear_store();
            scan_pos    = 2'd0;
            blink_sel   = 8'h00;
            blink_lit   = 1'b1;
            blink_timer = 12'd0;
            shown       = 1'b1;
            leds        = 4'h0;
            half_period = 12'd200;
            hold_ticks  = 12'd800;
            scan_words_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_DISPLAY_ON:  shown       = i_cfg_data[0];
                    REG_LED_STATE:   leds        = i_cfg_data[3:0];
                    REG_HALF_PERIOD: half_period = i_cfg_data[11:0];
                    REG_HOLD_TIME:   hold_ticks  = i_cfg_data[11:0];
                    default: ;
                endcase
            end
            // A word taken now belongs to an earlier tick, so compare before predicting.
            if (i_m_tvalid && i_m_tready) begin
                if (scan_words_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%t: shift word %06h with none expected", $time, i_m_tdata);
                end else begin
                    want = scan_words_due.pop_front();
                    if (i_m_tdata !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("%t: shift_word expected %06h, got %06h",
                                     $time, want, i_m_tdata);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_request(i_s_tuser, i_s_tdata);
            end
        end
        o_pending    <= scan_words_due.size();
        o_fail_count <= mismatches;
    end

endmodule

/* bench/seven_segment_mux_display_test.sv */
// Top of the display controller bench: clock, reset, request and register stimulus,
// receiver back-pressure, watchdog and verdict. Depends on ssmd_pkg and the checker.
module seven_segment_mux_display_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ssmd_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int IDLE_LIMIT      = 1000;
    localparam int DRAIN_CYCLES    = 4;

    // Kinds past clear carry no meaning; the block must swallow them quietly.
    localparam logic [2:0] K_SPARE_LO = 3'd5;
    localparam logic [2:0] K_SPARE_HI = 3'd7;

    localparam logic [6:0] CHAR_ZERO = 7'h30;
    localparam logic [7:0] FONT_CHARS [0:22] = '{
        "A", "b", "c", "C", "d", "E", "F", "G", "H", "I", "L", "n",
        "o", "O", "P", "r", "S", "t", "u", "U", "Y", "*", " "
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;   // [7:0] char, [9:8] row, [12:10] digit,
                                        // [20:13] blink select, [21] keep, [23:22] zero
    logic [2:0]            i_s_tuser;   // [2:0] kind
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;   // [23:0] shift word
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int pending;
    int fail_count;
    int idle_cycles;
    int hold_requests = 0;  // bumped by the stimulus, served by the receiver
    bit tx_dense;           // no sender gaps while set

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    seven_segment_mux_display DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    seven_segment_mux_display_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Pack the request fields into tdata, first field in the lowest bits.
    function automatic logic [IN_DATA_W-1:0] pack_request(
        input logic [7:0] code,
        input logic [1:0] row,
        input logic [2:0] digit,
        input logic [7:0] sel,
        input logic       keep
    );
        return {2'b00, keep, sel, digit, row, code};
    endfunction

    // Offer one word and hold it until taken; then maybe drop valid for a gap.
    // Valid is never dropped and raised in the same step, so back-to-back words
    // keep it high.
    task automatic send_request(input logic [2:0] kind, input logic [IN_DATA_W-1:0] data);
        int r;
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_tready);
        r = $urandom_range(0, 99);
        if (tx_dense || r < 55)
            gap = 0;
        else if (r < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 30);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic random_request();
        logic [7:0] code;
        logic [1:0] row;
        logic [2:0] digit;
        logic [2:0] kind;
        int         r;
        code  = 8'($urandom);
        row   = 2'($urandom);
        digit = 3'($urandom);
        r     = $urandom_range(0, 99);
        if (r < 50) begin
            kind = K_TICK;
        end else if (r < 75) begin
            kind = K_PUT_CHAR;
            // Favor characters with a real glyph; keep some unknown codes for the dash.
            case ($urandom_range(0, 2))
                0:       code[6:0] = CHAR_ZERO + 7'($urandom_range(0, 9));
                1:       code[6:0] = FONT_CHARS[$urandom_range(0, 22)][6:0];
                default: ;
            endcase
        end else if (r < 85) begin
            kind = K_SET_CURSOR;
            if ($urandom_range(0, 9) < 7) begin
                row   = 2'($urandom_range(0, ROW_COUNT - 1));
                digit = 3'($urandom_range(0, DIGITS - 1));
            end
        end else if (r < 92) begin
            kind = K_SET_BLINK;
        end else if (r < 96) begin
            kind = K_CLEAR;
        end else begin
            kind = 3'($urandom_range(K_SPARE_LO, K_SPARE_HI));
        end
        send_request(kind, pack_request(code, row, digit, 8'($urandom),
                                        $urandom_range(0, 3) == 0));
    endtask

    // Drop valid, wait until every shift word is back, then let the pipe empty.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Receiver: random ready pattern, plus a long hold-off whenever asked.
    initial begin
        int   served;
        int   len;
        logic level;
        served = 0;
        forever begin
            if (hold_requests != served) begin
                served++;
                level = 1'b0;
                len   = HOLD_OFF_CYCLES;
            end else if ($urandom_range(0, 2) == 0) begin
                level = 1'b0;
                len   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 3);
            end else begin
                level = 1'b1;
                len   = $urandom_range(1, 30);
            end
            i_m_tready <= level;
            repeat (len) @(posedge i_clk);
        end
    end

    // Watchdog: end the run when nothing moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic        on;
        logic [3:0]  led;
        logic [11:0] half;
        logic [11:0] hold;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= K_TICK;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_DISPLAY_ON;
        i_cfg_data  <= '0;
        tx_dense    = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words under the reset register values.
        send_request(K_TICK, '0);
        // Fill row one: direct codes at both ends, a digit, a digit with the point.
        send_request(K_PUT_CHAR, pack_request(8'h00, 2'd0, 3'd0, 8'h00, 1'b0));
        send_request(K_PUT_CHAR, pack_request(8'h0F, 2'd0, 3'd0, 8'h00, 1'b0));
        send_request(K_PUT_CHAR, pack_request("0", 2'd0, 3'd0, 8'h00, 1'b0));
        send_request(K_PUT_CHAR, pack_request(8'hB9, 2'd0, 3'd0, 8'h00, 1'b0));
        // Row two: a letter, an unknown symbol, blank, star; the cursor wraps after.
        send_request(K_PUT_CHAR, pack_request("A", 2'd0, 3'd0, 8'h00, 1'b0));
        send_request(K_PUT_CHAR, pack_request(8'h7F, 2'd0, 3'd0, 8'h00, 1'b0));
        send_request(K_PUT_CHAR, pack_request(" ", 2'd0, 3'd0, 8'h00, 1'b0));
        send_request(K_PUT_CHAR, pack_request("*", 2'd0, 3'd0, 8'h00, 1'b0));
        send_request(K_PUT_CHAR, pack_request(8'hC8, 2'd0, 3'd0, 8'h00, 1'b0));
        // Out-of-range cursors are ignored; the last one is valid.
        send_request(K_SET_CURSOR, pack_request(8'hFF, 2'd3, 3'd7, 8'hFF, 1'b1));
        send_request(K_SET_CURSOR, pack_request(8'h00, 2'd1, 3'd4, 8'h00, 1'b0));
        send_request(K_SET_CURSOR, pack_request(8'h00, 2'd1, 3'd3, 8'h00, 1'b0));
        send_request(K_PUT_CHAR, pack_request("E", 2'd0, 3'd0, 8'h00, 1'b0));
        send_request(K_SPARE_LO, pack_request(8'hFF, 2'd3, 3'd7, 8'hFF, 1'b1));
        send_request(K_SPARE_HI, pack_request(8'h55, 2'd1, 3'd2, 8'hAA, 1'b0));
        repeat (DIGITS) send_request(K_TICK, '0);
        // Blink every digit, then hold it lit with a write, then keep the mask.
        send_request(K_SET_BLINK, pack_request(8'h00, 2'd0, 3'd0, 8'hFF, 1'b0));
        send_request(K_TICK, '0);
        send_request(K_PUT_CHAR, pack_request("P", 2'd0, 3'd0, 8'h00, 1'b0));
        send_request(K_SET_BLINK, pack_request(8'h00, 2'd0, 3'd0, 8'h00, 1'b1));
        send_request(K_TICK, '0);
        send_request(K_CLEAR, '0);
        send_request(K_TICK, '0);

        for (int phase = 0; phase < PHASES; phase++) begin
            // Sender pauses here until every shift word has come back.
            settle();
            case (phase)
                0: begin on = 1'b1; led = 4'hF; half = 12'd1;    hold = 12'd1;    end
                // Zero timers: masked digits toggle on every tick.
                1: begin on = 1'b0; led = 4'h0; half = 12'd0;    hold = 12'd0;    end
                2: begin on = 1'b1; led = 4'h5; half = 12'd4095; hold = 12'd4095; end
                3: begin on = 1'b0; led = 4'hA; half = 12'd2;    hold = 12'd9;    end
                default: begin
                    on   = 1'($urandom);
                    led  = 4'($urandom);
                    half = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(1, 4095))
                                                       : 12'($urandom_range(1, 6));
                    hold = 12'($urandom_range(1, 15));
                end
            endcase
            write_register(REG_DISPLAY_ON, CFG_DATA_W'(on));
            write_register(REG_LED_STATE, CFG_DATA_W'(led));
            write_register(REG_HALF_PERIOD, half);
            write_register(REG_HOLD_TIME, hold);
            i_cfg_valid <= 1'b0;

            tx_dense = (phase % 3 == 1);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // Stall the receiver for a long stretch while words keep coming.
                if ((phase == 2 || phase == 5) && k == ITEMS_PER_PHASE / 4)
                    hold_requests <= hold_requests + 1;
                random_request();
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
